FILE: rtl/text_to_integer_parser_macros.svh
// assertion helpers, sampled on clk, off while arst_n is low
`ifndef TEXT_TO_INTEGER_PARSER_MACROS_SVH
`define TEXT_TO_INTEGER_PARSER_MACROS_SVH

`define TTIP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define TTIP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ttip_pkg.sv
package ttip_pkg;

	localparam int CHAR_W         = 8;
	localparam int BASE_W         = 6;
	localparam int STATUS_W       = 2;
	localparam int COUNT_W        = 13;
	localparam int MAX_COUNT_DEF  = 4096;
	localparam int VALUE_BITS_DEF = 64;

	localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
	localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
	localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
	localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
	localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
	localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
	localparam logic [BASE_W-1:0] BASE_RESET = BASE_DEC;

	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NO_DIGIT = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_BAD_BASE = 2'd3;

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
	localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;

	localparam logic [BASE_W-1:0] DIGIT_TEN = 6'd10;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SPACE,
		PH_SIGNED,
		PH_ZERO,
		PH_PREFIX,
		PH_DIGITS,
		PH_SKIP
	} phase_t;

	typedef enum logic {
		C_WAIT,
		C_MAC
	} ctl_t;

	typedef enum logic [1:0] {
		A_NONE,
		A_FINISH,
		A_BAD,
		A_MAC
	} act_t;

	typedef struct packed {
		logic              valid;
		logic [BASE_W-1:0] value;
	} digit_t;

	typedef struct packed {
		logic              start;
		logic [BASE_W-1:0] base;
		logic [BASE_W-1:0] digit;
	} mac_req_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} mac_rsp_t;

	function automatic digit_t digit_of(input logic [CHAR_W-1:0] c);
		digit_t d;
		d.valid = 1'b1;
		d.value = '0;
		if (c >= CH_0 && c <= CH_9) begin
			d.value = BASE_W'(c - CH_0);
		end else if (c >= CH_LA && c <= CH_LZ) begin
			d.value = BASE_W'(c - CH_LA) + DIGIT_TEN;
		end else if (c >= CH_UA && c <= CH_UZ) begin
			d.value = BASE_W'(c - CH_UA) + DIGIT_TEN;
		end else begin
			d.valid = 1'b0;
		end
		return d;
	endfunction

endpackage

FILE: rtl/ttip_char_if.sv
interface ttip_char_if;
	logic                         valid;
	logic                         ready;
	logic [ttip_pkg::CHAR_W-1:0]  character;
	logic                         start_of_text;

	modport source (output valid, output character, output start_of_text, input ready);
	modport sink (input valid, input character, input start_of_text, output ready);
endinterface

FILE: rtl/ttip_base_if.sv
interface ttip_base_if;
	logic                        valid;
	logic                        ready;
	logic [ttip_pkg::BASE_W-1:0] number_base;

	modport source (output valid, output number_base, input ready);
	modport sink (input valid, input number_base, output ready);
endinterface

FILE: rtl/ttip_result_if.sv
interface ttip_result_if #(
	parameter int VALUE_BITS = ttip_pkg::VALUE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic [VALUE_BITS-1:0]         parsed_value;
	logic [ttip_pkg::STATUS_W-1:0] status_code;
	logic [ttip_pkg::COUNT_W-1:0]  chars_consumed;

	modport source (output valid, output parsed_value, output status_code,
		output chars_consumed, input ready);
	modport sink (input valid, input parsed_value, input status_code,
		input chars_consumed, output ready);
endinterface

FILE: rtl/text_to_integer_parser.sv
// Streaming strtoull-style parser: one text byte per word on the text channel,
// start_of_text marks the first byte of a string, number_base is latched then.
// Whitespace, sign, prefix and terminating bytes, and digits that follow an
// overflow, are taken without the multiplier; any other digit in the active base
// holds the text channel until the shift-add multiplier is done: it loads at
// acceptance, does a shift-add step for each bit of the base, adds the digit,
// and the product is written back before the next byte can be taken.
// One result word is given at the byte that ends the number; it sits in an
// output register, and no byte is taken while it waits unaccepted.
module text_to_integer_parser #(
	parameter int MAX_COUNT  = ttip_pkg::MAX_COUNT_DEF,
	parameter int VALUE_BITS = ttip_pkg::VALUE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ttip_base_if.sink     cfg,
	ttip_char_if.sink     text,
	ttip_result_if.source result
);

	localparam int CNT_W = $clog2(MAX_COUNT + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_COUNT);

	logic [ttip_pkg::BASE_W-1:0] number_base_q;

	ttip_pkg::ctl_t              ctl_q, ctl_d;
	ttip_pkg::phase_t            phase_q, phase_d, ph;
	logic [ttip_pkg::BASE_W-1:0] eb_q, eb_d, eb;
	logic [VALUE_BITS-1:0]       acc_q, acc_d, acc;
	logic                        minus_q, minus_d, minus;
	logic [CNT_W-1:0]            cnt_q, cnt_d, cnt;
	logic                        ovf_q, ovf_d, ovf;
	logic                        ds_q, ds_d, ds;

	ttip_pkg::act_t              act;
	ttip_pkg::digit_t            dig;
	logic [ttip_pkg::CHAR_W-1:0] c;
	logic                        step, start_num;
	logic [ttip_pkg::BASE_W-1:0] step_base;
	logic [CNT_W-1:0]            step_cnt;
	logic                        is_space, in_base;

	logic [VALUE_BITS-1:0]         fin_value;
	logic [ttip_pkg::STATUS_W-1:0] fin_status;
	logic [31:0]                   cnt_wide;

	logic                          text_ready, fire;
	ttip_pkg::mac_req_t            mac_req;
	ttip_pkg::mac_rsp_t            mac_rsp;
	logic [VALUE_BITS-1:0]         mac_result;

	logic                          res_valid_q;
	logic [VALUE_BITS-1:0]         res_value_q;
	logic [ttip_pkg::STATUS_W-1:0] res_status_q;
	logic [ttip_pkg::COUNT_W-1:0]  res_count_q;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
		return (x < CNT_MAX) ? x + CNT_W'(1) : x;
	endfunction

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= ttip_pkg::BASE_RESET;
		end else if (cfg.valid) begin
			number_base_q <= cfg.number_base;
		end
	end

	// view of the state as this byte sees it, a new string starts clean
	assign c   = text.character;
	assign dig = ttip_pkg::digit_of(c);

	always_comb begin
		ph    = text.start_of_text ? ttip_pkg::PH_SPACE : phase_q;
		eb    = text.start_of_text ? number_base_q : eb_q;
		acc   = text.start_of_text ? '0 : acc_q;
		minus = text.start_of_text ? 1'b0 : minus_q;
		cnt   = text.start_of_text ? '0 : cnt_q;
		ovf   = text.start_of_text ? 1'b0 : ovf_q;
		ds    = text.start_of_text ? 1'b0 : ds_q;
	end

	assign is_space = (c == ttip_pkg::CH_SPACE) || (c >= ttip_pkg::CH_TAB && c <= ttip_pkg::CH_CR);
	assign in_base  = dig.valid && (dig.value < eb);

	always_comb begin
		fin_value  = '0;
		fin_status = ttip_pkg::STAT_NO_DIGIT;
		if (ds && ovf) begin
			fin_value  = '1;
			fin_status = ttip_pkg::STAT_RANGE;
		end else if (ds) begin
			fin_value  = minus ? ('0 - acc) : acc;
			fin_status = ttip_pkg::STAT_OK;
		end
	end

	assign cnt_wide = 32'(cnt);

	// parse decision for the byte on the text channel
	always_comb begin
		phase_d   = ph;
		eb_d      = eb;
		acc_d     = acc;
		minus_d   = minus;
		cnt_d     = cnt;
		ovf_d     = ovf;
		ds_d      = ds;
		act       = ttip_pkg::A_NONE;
		step      = 1'b0;
		start_num = 1'b0;
		step_base = eb;
		step_cnt  = cnt;
		case (ph)
			ttip_pkg::PH_IDLE: begin
			end
			ttip_pkg::PH_SPACE: begin
				if (is_space) begin
					cnt_d = sat_inc(cnt);
				end else if (c == ttip_pkg::CH_PLUS || c == ttip_pkg::CH_MINUS) begin
					minus_d = (c == ttip_pkg::CH_MINUS);
					cnt_d   = sat_inc(cnt);
					phase_d = ttip_pkg::PH_SIGNED;
				end else begin
					start_num = 1'b1;
				end
			end
			ttip_pkg::PH_SIGNED: begin
				start_num = 1'b1;
			end
			ttip_pkg::PH_ZERO: begin
				if (c == ttip_pkg::CH_LX || c == ttip_pkg::CH_UX) begin
					eb_d    = ttip_pkg::BASE_HEX;
					phase_d = ttip_pkg::PH_PREFIX;
				end else begin
					step = 1'b1;
				end
			end
			ttip_pkg::PH_PREFIX: begin
				if (in_base) begin
					step     = 1'b1;
					step_cnt = sat_inc(cnt);
				end else begin
					act = ttip_pkg::A_FINISH;
				end
			end
			ttip_pkg::PH_DIGITS: begin
				step = 1'b1;
			end
			ttip_pkg::PH_SKIP: begin
				if (in_base) begin
					cnt_d = sat_inc(cnt);
				end else begin
					act = ttip_pkg::A_FINISH;
				end
			end
			default: begin
			end
		endcase

		if (start_num) begin
			if (eb == ttip_pkg::BASE_ONE || eb > ttip_pkg::BASE_MAX) begin
				act = ttip_pkg::A_BAD;
			end else if (c == ttip_pkg::CH_0 &&
				(eb == ttip_pkg::BASE_AUTO || eb == ttip_pkg::BASE_HEX)) begin
				ds_d    = 1'b1;
				acc_d   = '0;
				cnt_d   = sat_inc(cnt);
				eb_d    = (eb == ttip_pkg::BASE_AUTO) ? ttip_pkg::BASE_OCT : ttip_pkg::BASE_HEX;
				phase_d = ttip_pkg::PH_ZERO;
			end else begin
				step      = 1'b1;
				step_base = (eb == ttip_pkg::BASE_AUTO) ? ttip_pkg::BASE_DEC : eb;
			end
		end

		if (step) begin
			if (dig.valid && dig.value < step_base) begin
				act   = ttip_pkg::A_MAC;
				ds_d  = 1'b1;
				cnt_d = sat_inc(step_cnt);
				eb_d  = step_base;
			end else begin
				act = ttip_pkg::A_FINISH;
			end
		end

		if (act == ttip_pkg::A_FINISH || act == ttip_pkg::A_BAD) begin
			phase_d = ttip_pkg::PH_IDLE;
		end
	end

	// sequencer
	always_comb begin
		ctl_d = ctl_q;
		case (ctl_q)
			ttip_pkg::C_WAIT: begin
				if (fire && act == ttip_pkg::A_MAC) begin
					ctl_d = ttip_pkg::C_MAC;
				end
			end
			ttip_pkg::C_MAC: begin
				if (mac_rsp.done) begin
					ctl_d = ttip_pkg::C_WAIT;
				end
			end
			default: ctl_d = ttip_pkg::C_WAIT;
		endcase
	end

	always_comb begin
		text_ready    = 1'b0;
		mac_req.start = 1'b0;
		mac_req.base  = step_base;
		mac_req.digit = dig.value;
		case (ctl_q)
			ttip_pkg::C_WAIT: begin
				text_ready    = !res_valid_q || result.ready;
				mac_req.start = text.valid && text_ready && (act == ttip_pkg::A_MAC);
			end
			ttip_pkg::C_MAC: begin
			end
			default: begin
			end
		endcase
	end

	assign text.ready = text_ready;
	assign fire       = text.valid && text_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q   <= ttip_pkg::C_WAIT;
			phase_q <= ttip_pkg::PH_IDLE;
			eb_q    <= '0;
			acc_q   <= '0;
			minus_q <= 1'b0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			ds_q    <= 1'b0;
		end else begin
			ctl_q <= ctl_d;
			if (fire) begin
				phase_q <= phase_d;
				eb_q    <= eb_d;
				acc_q   <= acc_d;
				minus_q <= minus_d;
				cnt_q   <= cnt_d;
				ovf_q   <= ovf_d;
				ds_q    <= ds_d;
			end else if (ctl_q == ttip_pkg::C_MAC && mac_rsp.done) begin
				ovf_q   <= mac_rsp.ovf;
				acc_q   <= mac_rsp.ovf ? '1 : mac_result;
				phase_q <= mac_rsp.ovf ? ttip_pkg::PH_SKIP : ttip_pkg::PH_DIGITS;
			end
		end
	end

	ttip_mac #(
		.VALUE_BITS(VALUE_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.acc_in (acc),
		.rsp    (mac_rsp),
		.result (mac_result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire && (act == ttip_pkg::A_FINISH || act == ttip_pkg::A_BAD)) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && act == ttip_pkg::A_FINISH) begin
			res_value_q  <= fin_value;
			res_status_q <= fin_status;
			res_count_q  <= ds ? cnt_wide[ttip_pkg::COUNT_W-1:0] : '0;
		end else if (fire && act == ttip_pkg::A_BAD) begin
			res_value_q  <= '0;
			res_status_q <= ttip_pkg::STAT_BAD_BASE;
			res_count_q  <= '0;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.parsed_value   = res_value_q;
	assign result.status_code    = res_status_q;
	assign result.chars_consumed = res_count_q;

endmodule

FILE: rtl/ttip_mac.sv
// acc * base + digit, one base bit per cycle (msb first), then the digit add
module ttip_mac #(
	parameter int VALUE_BITS = ttip_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ttip_pkg::mac_req_t    req,
	input  logic [VALUE_BITS-1:0] acc_in,
	output ttip_pkg::mac_rsp_t    rsp,
	output logic [VALUE_BITS-1:0] result
);

	localparam int PW     = VALUE_BITS + ttip_pkg::BASE_W + 1;
	localparam int STEP_W = $clog2(ttip_pkg::BASE_W + 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ttip_pkg::BASE_W);

	logic                        busy_q;
	logic                        done_q;
	logic [STEP_W-1:0]           step_q;
	logic [VALUE_BITS-1:0]       a_q;
	logic [ttip_pkg::BASE_W-1:0] b_q;
	logic [ttip_pkg::BASE_W-1:0] d_q;
	logic [PW-1:0]               p_q;
	logic [PW-1:0]               addend;

	assign addend = b_q[ttip_pkg::BASE_W-1] ? PW'(a_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q != LAST_STEP) begin
					step_q <= step_q + STEP_W'(1);
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= acc_in;
			b_q <= req.base;
			d_q <= req.digit;
			p_q <= '0;
		end else if (busy_q) begin
			if (step_q != LAST_STEP) begin
				p_q <= {p_q[PW-2:0], 1'b0} + addend;
				b_q <= {b_q[ttip_pkg::BASE_W-2:0], 1'b0};
			end else begin
				p_q <= p_q + PW'(d_q);
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.ovf  = |p_q[PW-1:VALUE_BITS];
	assign result   = p_q[VALUE_BITS-1:0];

endmodule

FILE: rtl/ttip_checker.sv
`include "text_to_integer_parser_macros.svh"

module ttip_checker #(
	parameter int VALUE_BITS = ttip_pkg::VALUE_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          text_valid,
	input logic                          text_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [VALUE_BITS-1:0]         parsed_value,
	input logic [ttip_pkg::STATUS_W-1:0] status_code,
	input logic [ttip_pkg::COUNT_W-1:0]  chars_consumed
);

	// a result word only appears right after a byte was taken
	`TTIP_ASSERT_NOW(a_res_follows_byte, $rose(res_valid), $past(text_valid && text_ready), "result without a byte")

	`TTIP_ASSERT_NOW(a_empty_result, res_valid && (status_code == ttip_pkg::STAT_NO_DIGIT || status_code == ttip_pkg::STAT_BAD_BASE), parsed_value == '0 && chars_consumed == '0, "nonzero empty result")

	`TTIP_ASSERT_NOW(a_range_saturates, res_valid && status_code == ttip_pkg::STAT_RANGE, &parsed_value, "overflow not all ones")

	`TTIP_ASSERT_NEXT(a_res_holds, res_valid && !res_ready, res_valid && $stable(parsed_value) && $stable(status_code), "stalled word changed")

endmodule

bind text_to_integer_parser ttip_checker #(
	.VALUE_BITS(VALUE_BITS)
) u_ttip_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.text_valid     (text.valid),
	.text_ready     (text.ready),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.parsed_value   (result.parsed_value),
	.status_code    (result.status_code),
	.chars_consumed (result.chars_consumed)
);
